### sv/lzsd_pkg.sv
package lzsd_pkg;

   // history window and counters
   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_BITS     = $clog2(WINDOW_DEPTH);
   localparam int COUNT_BITS   = 24;
   localparam int CMP_BITS     = COUNT_BITS + 1;
   localparam int CFG_BITS     = 24;

   // token layout
   localparam int DIST_BITS  = 12;
   localparam int LEN_BITS   = 5;
   localparam int LEN_BIAS   = 3;
   localparam int FLAG_ITEMS = 8;
   localparam int FPOS_BITS  = 4;

   // command queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_BITS  = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DONE,
      ST_TRUNC,
      ST_BADREF
   } status_type;

   typedef enum logic [1:0] {
      OP_LITERAL,
      OP_COPY,
      OP_STATUS
   } op_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_READ,
      BACK_EMIT
   } back_state_type;

   // one decoded action for the back end
   typedef struct packed {
      op_type                op;
      logic [7:0]            data;
      logic [DIST_BITS-1:0]  distance;
      logic [LEN_BITS-1:0]   len;
      logic [WIN_BITS-1:0]   pos;
      status_type            status;
   } cmd_type;

endpackage

### sv/lzsd_ram.sv
module lzsd_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 4096,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lzsd_cmd_fifo.sv
module lzsd_cmd_fifo
   import lzsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_BITS:0]   count_ff, count_in;

   assign full  = (count_ff == (FIFO_BITS+1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // queue never overflows or underflows
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("command pushed into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("command popped from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_BITS+1)'(FIFO_DEPTH))
      else $error("queue fill level out of range");

endmodule

### sv/lzsd_front.sv
module lzsd_front
   import lzsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                req_tlast,
   input  logic                csr_wr_en,
   input  logic [CFG_BITS-1:0] csr_wr_data,
   input  logic                fifo_full,
   output logic                push,
   output cmd_type             push_cmd
);

   logic [CFG_BITS-1:0]   out_len_ff;
   logic [COUNT_BITS-1:0] prod_ff, prod_in;
   logic [7:0]            flags_ff, flags_in;
   logic [FPOS_BITS-1:0]  fpos_ff, fpos_in;
   logic [7:0]            tlow_ff, tlow_in;
   logic                  await_ff, await_in;
   logic                  over_ff, over_in;

   logic                  accept;
   logic [COUNT_BITS-1:0] e_prod;
   logic [7:0]            e_flags;
   logic [FPOS_BITS-1:0]  e_fpos;
   logic                  e_await;
   logic                  e_over;
   logic [DIST_BITS-1:0]  tok_dist;
   logic [LEN_BITS-1:0]   tok_len;
   logic [CMP_BITS-1:0]   prod_ext;
   logic [CMP_BITS-1:0]   len_ext;
   logic [CMP_BITS-1:0]   copy_end;
   logic [COUNT_BITS-1:0] lit_prod;
   logic                  bad_ref;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;

   // state as seen by this request, after a stream start clears it
   assign e_prod  = req_tuser ? '0 : prod_ff;
   assign e_flags = req_tuser ? '0 : flags_ff;
   assign e_fpos  = req_tuser ? FPOS_BITS'(FLAG_ITEMS) : fpos_ff;
   assign e_await = req_tuser ? 1'b0 : await_ff;
   assign e_over  = req_tuser ? 1'b0 : over_ff;

   // token fields and range checks
   assign tok_dist = {req_tdata[3:0], tlow_ff};
   assign tok_len  = LEN_BITS'(req_tdata[7:4]) + LEN_BITS'(LEN_BIAS);
   assign prod_ext = {1'b0, e_prod};
   assign len_ext  = CMP_BITS'(out_len_ff);
   assign copy_end = prod_ext + CMP_BITS'(tok_len);
   assign lit_prod = e_prod + 1'b1;
   assign bad_ref  = (tok_dist == '0) || (CMP_BITS'(tok_dist) > prod_ext)
                     || (copy_end > len_ext);

   // classify the request and build the command
   always_comb begin
      prod_in  = prod_ff;
      flags_in = flags_ff;
      fpos_in  = fpos_ff;
      tlow_in  = tlow_ff;
      await_in = await_ff;
      over_in  = over_ff;
      push     = 1'b0;
      push_cmd.op       = OP_STATUS;
      push_cmd.data     = req_tdata;
      push_cmd.distance = tok_dist;
      push_cmd.len      = '0;
      push_cmd.pos      = e_prod[WIN_BITS-1:0];
      push_cmd.status   = ST_RUN;
      if (accept) begin
         prod_in  = e_prod;
         flags_in = e_flags;
         fpos_in  = e_fpos;
         await_in = e_await;
         over_in  = e_over;
         if (e_over) begin
            // stream over: ignore
         end else if (prod_ext >= len_ext) begin
            over_in         = 1'b1;
            push            = 1'b1;
            push_cmd.status = ST_DONE;
         end else if (e_fpos >= FPOS_BITS'(FLAG_ITEMS)) begin
            // flag byte
            flags_in = req_tdata;
            fpos_in  = '0;
            if (req_tlast) begin
               over_in         = 1'b1;
               push            = 1'b1;
               push_cmd.status = ST_TRUNC;
            end
         end else if (!e_flags[e_fpos[2:0]]) begin
            // literal byte
            push         = 1'b1;
            push_cmd.op  = OP_LITERAL;
            push_cmd.len = LEN_BITS'(1);
            prod_in      = lit_prod;
            fpos_in      = e_fpos + 1'b1;
            if (lit_prod >= COUNT_BITS'(out_len_ff)) begin
               over_in         = 1'b1;
               push_cmd.status = ST_DONE;
            end else if (req_tlast) begin
               over_in         = 1'b1;
               push_cmd.status = ST_TRUNC;
            end
         end else if (!e_await) begin
            // token low byte
            tlow_in  = req_tdata;
            await_in = 1'b1;
            if (req_tlast) begin
               over_in         = 1'b1;
               push            = 1'b1;
               push_cmd.status = ST_TRUNC;
            end
         end else begin
            // token high byte completes a back reference
            await_in = 1'b0;
            push     = 1'b1;
            if (bad_ref) begin
               over_in         = 1'b1;
               push_cmd.status = ST_BADREF;
            end else begin
               push_cmd.op  = OP_COPY;
               push_cmd.len = tok_len;
               prod_in      = copy_end[COUNT_BITS-1:0];
               fpos_in      = e_fpos + 1'b1;
               if (copy_end >= len_ext) begin
                  over_in         = 1'b1;
                  push_cmd.status = ST_DONE;
               end else if (req_tlast) begin
                  over_in         = 1'b1;
                  push_cmd.status = ST_TRUNC;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_len_ff <= CFG_BITS'(1);
         prod_ff    <= '0;
         flags_ff   <= '0;
         fpos_ff    <= FPOS_BITS'(FLAG_ITEMS);
         tlow_ff    <= '0;
         await_ff   <= 1'b0;
         over_ff    <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            out_len_ff <= csr_wr_data;
         end
         prod_ff  <= prod_in;
         flags_ff <= flags_in;
         fpos_ff  <= fpos_in;
         tlow_ff  <= tlow_in;
         await_ff <= await_in;
         over_ff  <= over_in;
      end
   end

endmodule

### sv/lzsd_back.sv
module lzsd_back
   import lzsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fifo_empty,
   input  cmd_type    fifo_head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [2:0] rsp_tuser,
   output logic       rsp_tlast
);

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [LEN_BITS-1:0]   left_ff, left_in;
   logic [WIN_BITS-1:0]   pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic [2:0]            rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  is_last;
   logic                  has_byte;
   logic [7:0]            emit_byte;
   status_type            emit_status;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [WIN_BITS-1:0]   ram_rd_addr;
   logic [7:0]            ram_rd_data;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign is_last     = (cmd_ff.op == OP_STATUS) || (left_ff == LEN_BITS'(1));
   assign has_byte    = (cmd_ff.op != OP_STATUS);
   assign emit_status = is_last ? cmd_ff.status : ST_RUN;
   assign ram_rd_addr = pos_ff - WIN_BITS'(cmd_ff.distance);

   // byte for the current item
   always_comb begin
      case (cmd_ff.op)
         OP_COPY:    emit_byte = ram_rd_data;
         OP_LITERAL: emit_byte = cmd_ff.data;
         default:    emit_byte = '0;
      endcase
   end

   // history window
   lzsd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (emit_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer: fetch command, read history, emit one item
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         BACK_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               cmd_in   = fifo_head;
               pos_in   = fifo_head.pos;
               left_in  = fifo_head.len;
               state_in = (fifo_head.op == OP_COPY) ? BACK_READ : BACK_EMIT;
            end
         end
         BACK_READ: begin
            ram_rd_en = 1'b1;
            state_in  = BACK_EMIT;
         end
         BACK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = emit_byte;
               rsp_user_in  = {emit_status, has_byte};
               rsp_last_in  = is_last;
               if (has_byte) begin
                  ram_wr_en = 1'b1;
                  pos_in    = pos_ff + 1'b1;
                  left_in   = left_ff - 1'b1;
               end
               state_in = is_last ? BACK_IDLE : BACK_READ;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      left_ff     <= left_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // copy and literal never emit past their byte count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_EMIT && cmd_ff.op == OP_COPY) |-> (left_ff != '0))
      else $error("copy emits with no bytes left");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_EMIT && cmd_ff.op == OP_LITERAL) |-> (left_ff == LEN_BITS'(1)))
      else $error("literal with wrong byte count");
   // a status-only item or a nonzero status always closes the request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (!rsp_user_ff[0] || rsp_user_ff[2:1] != ST_RUN)) |-> rsp_last_ff)
      else $error("status item without run end");

endmodule

### sv/lzss_stream_decoder_core.sv
// LZSS stream decoder, 4096-byte history window.
// req channel: one compressed byte per request in req_tdata; req_tuser set
// starts a new stream, req_tlast marks the last available source byte.
// rsp channel: rsp_tdata carries a decoded byte, rsp_tuser holds has_byte
// (bit 0) and status (bits 2:1: running, done, truncated, bad reference),
// rsp_tlast closes the results caused by one request.
// csr_wr_en/csr_wr_data set the expected decoded length; write only while idle.
// The front end classifies one request per cycle while the queue is not full
// and queues up to four commands; flag bytes and token low bytes produce no
// result unless they end the stream. A literal or status item is fetched from
// the queue and then emitted; a copy is fetched, then each byte is read from
// the window (registered read) and emitted, so a copy takes no new command
// until its last byte is out. A result passes through the queue, the command
// register and the result register. When rsp_tready is low the result register holds; the
// queue keeps taking requests until it fills, then req_tready drops.
// Reset: no stream active (input ignored until a stream start), expected
// length 1, queue empty. The window needs no clearing.
module lzss_stream_decoder_core
   import lzsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // in_byte
   input  logic                req_tuser,   // first_byte
   input  logic                req_tlast,   // final_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic [2:0]          rsp_tuser,   // has_byte, status[1:0]
   output logic                rsp_tlast,   // run_end
   input  logic                csr_wr_en,
   input  logic [CFG_BITS-1:0] csr_wr_data  // out_length
);

   logic    fifo_full;
   logic    fifo_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type fifo_head;

   // request classification
   lzsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fifo_full   (fifo_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // command queue
   lzsd_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .empty    (fifo_empty),
      .head     (fifo_head)
   );

   // execution and output
   lzsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_head  (fifo_head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### dv/lzss_stream_decoder_checker.sv
`timescale 1ns / 100ps

// watches both channels, decodes each accepted request on its own copy of
// the decoder state and compares every result against the oldest decoded item
module lzss_stream_decoder_checker
   import lzsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,    // in_byte
   input  logic                req_tuser,    // first_byte
   input  logic                req_tlast,    // final_byte
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [7:0]          rsp_tdata,    // out_byte
   input  logic [2:0]          rsp_tuser,    // has_byte, status[1:0]
   input  logic                rsp_tlast,    // run_end
   input  logic                csr_wr_en,
   input  logic [CFG_BITS-1:0] csr_wr_data,  // out_length
   output int                  fail_count,
   output int                  pending_count
);

   typedef struct {
      logic [7:0] data;
      logic       has_byte;
      status_type status;
      logic       run_end;
   } decoded_item_type;

   decoded_item_type decoded_q[$];
   decoded_item_type step_q[$];

   // decoder state as seen from outside
   logic [7:0]            window [WINDOW_DEPTH];
   logic [CFG_BITS-1:0]   out_length;
   logic [COUNT_BITS-1:0] produced;
   logic [7:0]            flag_bits;
   logic [FPOS_BITS-1:0]  flag_pos;
   logic [7:0]            token_lo;
   logic                  token_half;
   logic                  stream_idle;

   // one decoded byte goes to the window and to the staged results
   function automatic void emit(input logic [7:0] v);
      decoded_item_type it;
      window[produced[WIN_BITS-1:0]] = v;
      it.data     = v;
      it.has_byte = 1'b1;
      it.status   = ST_RUN;
      it.run_end  = 1'b0;
      step_q.push_back(it);
      produced = produced + 1'b1;
   endfunction

   // mark the last staged item, adding a status-only one if none was staged
   function automatic void close_step(input status_type st);
      decoded_item_type it;
      if (step_q.size() == 0) begin
         it.data     = 8'h00;
         it.has_byte = 1'b0;
      end else begin
         it = step_q.pop_back();
      end
      it.status  = st;
      it.run_end = 1'b1;
      step_q.push_back(it);
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
      step_q.delete();
   endfunction

   // decode one accepted request
   task automatic decode_request(input logic [7:0] b, input logic first, input logic fin);
      logic [15:0]          token;
      logic [DIST_BITS-1:0] tok_dist;
      logic [LEN_BITS-1:0]  len;
      step_q.delete();
      if (first) begin
         produced    = '0;
         flag_bits   = '0;
         flag_pos    = FPOS_BITS'(FLAG_ITEMS);
         token_lo    = '0;
         token_half  = 1'b0;
         stream_idle = 1'b0;
      end
      if (stream_idle) return;
      // length already reached: byte is dropped
      if (produced >= out_length) begin
         stream_idle = 1'b1;
         close_step(ST_DONE);
         return;
      end
      // flag byte
      if (flag_pos >= FPOS_BITS'(FLAG_ITEMS)) begin
         flag_bits = b;
         flag_pos  = '0;
         if (fin) begin
            stream_idle = 1'b1;
            close_step(ST_TRUNC);
         end
         return;
      end
      if (!flag_bits[flag_pos]) begin
         emit(b);
      end else if (!token_half) begin
         token_lo   = b;
         token_half = 1'b1;
         if (fin) begin
            stream_idle = 1'b1;
            close_step(ST_TRUNC);
         end
         return;
      end else begin
         token      = {b, token_lo};
         tok_dist   = token[DIST_BITS-1:0];
         len        = LEN_BITS'(token[15:12]) + LEN_BITS'(LEN_BIAS);
         token_half = 1'b0;
         if (tok_dist == '0 || COUNT_BITS'(tok_dist) > produced ||
             CMP_BITS'(produced) + CMP_BITS'(len) > CMP_BITS'(out_length)) begin
            stream_idle = 1'b1;
            close_step(ST_BADREF);
            return;
         end
         for (int i = 0; i < len; i++) begin
            emit(window[WIN_BITS'(produced - COUNT_BITS'(tok_dist))]);
         end
      end
      flag_pos = flag_pos + 1'b1;
      if (produced >= out_length) begin
         stream_idle = 1'b1;
         close_step(ST_DONE);
      end else if (fin) begin
         stream_idle = 1'b1;
         close_step(ST_TRUNC);
      end else begin
         close_step(ST_RUN);
      end
   endtask

   // compare one accepted result with the oldest decoded item
   task automatic check_result();
      decoded_item_type want;
      if (decoded_q.size() == 0) begin
         $error("result with nothing decoded: tdata %0h tuser %0h tlast %0b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         fail_count++;
      end else begin
         want = decoded_q.pop_front();
         if (rsp_tdata !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, rsp_tdata);
            fail_count++;
         end
         if (rsp_tuser[0] !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, rsp_tuser[0]);
            fail_count++;
         end
         if (rsp_tuser[2:1] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_tuser[2:1]);
            fail_count++;
         end
         if (rsp_tlast !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, rsp_tlast);
            fail_count++;
         end
      end
   endtask

   // register writes, requests and results at each edge
   always @(posedge clock) begin
      if (reset) begin
         out_length  = CFG_BITS'(1);
         produced    = '0;
         flag_bits   = '0;
         flag_pos    = FPOS_BITS'(FLAG_ITEMS);
         token_lo    = '0;
         token_half  = 1'b0;
         stream_idle = 1'b1;
         fail_count  = 0;
         decoded_q.delete();
         step_q.delete();
      end else begin
         if (csr_wr_en) out_length = csr_wr_data;
         if (req_tvalid && req_tready) decode_request(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      pending_count <= decoded_q.size();
   end

endmodule

### dv/lzss_stream_decoder_core_tb.sv
`timescale 1ns / 100ps

module lzss_stream_decoder_core_tb
   import lzsd_pkg::*;
();

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata   = 8'h00;
   logic                req_tuser   = 1'b0;
   logic                req_tlast   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [7:0]          rsp_tdata;
   logic [2:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_wr_en   = 1'b0;
   logic [CFG_BITS-1:0] csr_wr_data = '0;

   int fail_count;
   int pending_count;

   bit       idle_on   = 1'b1;
   int       hold_req  = 0;
   int       hold_done = 0;
   bit [7:0] src_q[$];
   int       src_sent  = 0;

   lzss_stream_decoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lzss_stream_decoder_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random idling, plus a long hold-off on demand
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req != hold_done) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_done = hold_req;
         end
         rsp_tready <= !(idle_on && $urandom_range(0, 99) < 13);
      end
   end

   // offer one source byte and wait for its request to be taken
   task automatic push_source_byte(input logic [7:0] b, input logic first, input logic fin);
      while (idle_on && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and let every decoded byte drain out
   task automatic wait_decoder_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_out_length(input logic [CFG_BITS-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // build a compressed stream of up to min(olen, cap) bytes; tokens only
   // reach back into bytes of this stream, one may be spoiled on request
   task automatic compose_stream(input int unsigned olen, input int unsigned cap,
                                 input int tok_pct, input bit want_bad);
      int unsigned goal, made, room, len, tok_dist, top_len, head;
      bit [7:0]    flags;
      bit          spoiled;
      goal    = (olen < cap) ? olen : cap;
      made    = 0;
      spoiled = !want_bad;
      src_q.delete();
      while (made < goal) begin
         head  = src_q.size();
         flags = 8'($urandom);
         src_q.push_back(8'h00);
         for (int k = 0; k < 8 && made < goal; k++) begin
            room = goal - made;
            if (made > 0 && room >= 3 && $urandom_range(0, 99) < tok_pct) begin
               top_len  = (room < 18) ? room : 18;
               len      = $urandom_range(3, top_len);
               tok_dist = $urandom_range(1, (made < 4095) ? made : 4095);
               if (!spoiled && $urandom_range(0, 2) == 0) begin
                  spoiled = 1'b1;
                  case ($urandom_range(0, 2))
                     0: tok_dist = 0;
                     1: begin
                        if (made < 4095) tok_dist = $urandom_range(made + 1, 4095);
                        else tok_dist = 0;
                     end
                     default: begin
                        if (olen - made < 18) len = $urandom_range(olen - made + 1, 18);
                        else tok_dist = 0;
                     end
                  endcase
               end
               flags[k] = 1'b1;
               src_q.push_back(tok_dist[7:0]);
               src_q.push_back({4'(len - 3), tok_dist[11:8]});
               made += len;
            end else begin
               flags[k] = 1'b0;
               src_q.push_back(8'($urandom));
               made++;
            end
         end
         src_q[head] = flags;
      end
   endtask

   // send the composed stream, cut short with a final byte at stop_at if set
   task automatic play_stream(input int stop_at, input bit fin_last);
      bit last;
      for (int i = 0; i < src_q.size(); i++) begin
         last = (i == stop_at) || (fin_last && i == src_q.size() - 1);
         push_source_byte(src_q[i], i == 0, last);
         src_sent++;
         if (i == stop_at) break;
      end
   endtask

   initial begin
      int unsigned olen;
      int          mode;
      int          stop_at;
      int          setting;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // byte before any stream start is dropped
      push_source_byte(8'h5A, 1'b0, 1'b0);
      // reset length of one, final byte on the literal that completes it
      push_source_byte(8'h00, 1'b1, 1'b0);
      push_source_byte(8'hFF, 1'b0, 1'b1);

      wait_decoder_idle();
      write_out_length(40);
      // two literals, longest copy, shortest copy, then zero distance
      push_source_byte(8'h1C, 1'b1, 1'b0);
      push_source_byte(8'h00, 1'b0, 1'b0);
      push_source_byte(8'h80, 1'b0, 1'b0);
      push_source_byte(8'h01, 1'b0, 1'b0);
      push_source_byte(8'hF0, 1'b0, 1'b0);
      push_source_byte(8'h02, 1'b0, 1'b0);
      push_source_byte(8'h00, 1'b0, 1'b0);
      push_source_byte(8'h00, 1'b0, 1'b0);
      push_source_byte(8'h00, 1'b0, 1'b0);
      // distance beyond the bytes produced so far
      push_source_byte(8'h02, 1'b1, 1'b0);
      push_source_byte(8'h11, 1'b0, 1'b0);
      push_source_byte(8'h02, 1'b0, 1'b0);
      push_source_byte(8'h00, 1'b0, 1'b0);

      wait_decoder_idle();
      write_out_length(4);
      // copy that would run past the length
      push_source_byte(8'h02, 1'b1, 1'b0);
      push_source_byte(8'h44, 1'b0, 1'b0);
      push_source_byte(8'h01, 1'b0, 1'b0);
      push_source_byte(8'h10, 1'b0, 1'b0);
      // source ends on a flag byte
      push_source_byte(8'h00, 1'b1, 1'b1);
      // source ends on a token low byte
      push_source_byte(8'h01, 1'b1, 1'b0);
      push_source_byte(8'h01, 1'b0, 1'b1);
      // source ends on a literal
      push_source_byte(8'h00, 1'b1, 1'b0);
      push_source_byte(8'h77, 1'b0, 1'b1);
      // two literals, then the length drops to what is already produced
      push_source_byte(8'h00, 1'b1, 1'b0);
      push_source_byte(8'h01, 1'b0, 1'b0);
      push_source_byte(8'h02, 1'b0, 1'b0);
      wait_decoder_idle();
      write_out_length(2);
      push_source_byte(8'hAB, 1'b0, 1'b0);
      push_source_byte(8'hCD, 1'b0, 1'b0);

      // result side holds off while a copy-heavy stream keeps coming back to back
      wait_decoder_idle();
      idle_on = 1'b0;
      write_out_length(200);
      hold_req++;
      compose_stream(200, 200, 70, 1'b0);
      play_stream(-1, 1'b0);

      // random settings, each with a few streams
      src_sent = 0;
      setting  = 0;
      while (src_sent < 40) begin
         case ($urandom_range(0, 9))
            0:       olen = 1;
            1:       olen = 24'hFFFFFF;
            2:       olen = 2;
            default: olen = $urandom_range(3, 48);
         endcase
         if (setting == 0) olen = 24'hFFFFFF;
         if (setting == 1) olen = 1;
         wait_decoder_idle();
         idle_on = (setting < 2 || setting > 4);
         write_out_length(olen);
         repeat ($urandom_range(1, 3)) begin
            mode = $urandom_range(0, 9);
            compose_stream(olen, 40, 50, mode == 6);
            stop_at = (mode == 7) ? $urandom_range(0, src_q.size() - 1) : -1;
            // stream left open, picked up by stray bytes or a new start
            if (mode == 8 && src_q.size() > 1) begin
               repeat ($urandom_range(1, src_q.size() - 1)) void'(src_q.pop_back());
            end
            play_stream(stop_at, mode < 6 && $urandom_range(0, 3) == 0);
            // stray bytes without a stream start
            repeat ($urandom_range(0, 2)) begin
               push_source_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
            end
         end
         setting++;
      end

      wait_decoder_idle();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
